[hdl/scd_pkg.sv]
// Package for the scanned seven-segment display: item types, codes,
// the segment table and the control struct between converter and scanner.
// No dependencies.
`default_nettype none

package scd_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int DIGIT_W    = 4;
	localparam int POS_W      = 3;
	localparam int PADDR_W    = 3;

	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_CURRENT = 2'd1;
	localparam logic [1:0] MODE_VOLTAGE = 2'd2;
	localparam logic [1:0] MODE_TIME    = 2'd3;

	localparam logic REG_POINT_MASK = 1'b0;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] value;
		logic [6:0]  hours;
		logic [6:0]  minutes;
	} in_item_t;

	typedef struct packed {
		logic [7:0] segments;
		logic [7:0] digit_select;
	} out_item_t;

	// one step of work for the scanner
	typedef struct packed {
		logic                     tick;
		logic                     load_lo;
		logic                     load_hi;
		logic [3:0][DIGIT_W-1:0]  digits;  // [0] goes to the lowest digit of the group
	} scd_cmd_t;

	function automatic logic [6:0] seg_pattern(input logic [DIGIT_W-1:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[hdl/scanned_seven_segment_display.sv]
// Top level of the eight-digit scanned seven-segment display driver.
// Depends on scd_pkg, scd_convert and scd_scan.
//
//   channel  | handshake               | payload
//   in       | in_valid / in_stall     | in_item  (mode, value, hours, minutes)
//   out      | out_valid / out_stall   | out_item (segments, digit_select)
//   config   | psel/penable/pwrite     | paddr, pwdata, prdata (point_mask)
//
// One item per cycle while in_stall is low: input register, conversion or scan, output register.
// A tick is held in item_s1 and its result is registered in the output register; loads give none.
// Reset clears digits to zero, scan to digit 0 and point_mask to zero.
// in_stall rises only when a tick waits on a stalled, full output register.
`default_nettype none

module scanned_seven_segment_display import scd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_item_t               out_item,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       out_free;
	logic       go_s1;
	logic [7:0] point_mask_q;
	scd_cmd_t   cmd;
	out_item_t  result;
	out_item_t  out_q;
	logic       out_valid_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_POINT_MASK) ? {24'd0, point_mask_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_mask_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_POINT_MASK) begin
			point_mask_q <= pwdata[7:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign go_s1 = valid_s1 && (item_s1.mode != MODE_TICK || out_free);
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_item;
	end

	scd_convert u_convert (
		.item (item_s1),
		.go   (go_s1),
		.cmd  (cmd)
	);

	scd_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.point_mask (point_mask_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

`default_nettype wire

[hdl/scd_convert.sv]
// Binary to decimal digit conversion for loads, and decode of the item mode.
// Depends on scd_pkg.
`default_nettype none

module scd_convert import scd_pkg::*; (
	input  wire in_item_t item,
	input  wire logic     go,
	output scd_cmd_t      cmd
);

	logic [32:0] p1, p2, p3, p4;
	logic [12:0] q1;
	logic [9:0]  q2;
	logic [6:0]  q3;
	logic [2:0]  q4;
	logic [15:0] r0;
	logic [12:0] r1;
	logic [9:0]  r2;
	logic [6:0]  r3;
	logic [14:0] tm, th;
	logic [3:0]  mt_raw, ht_raw, mt, ht;
	logic [6:0]  mo, ho;
	logic [3:0][DIGIT_W-1:0] val_digits, time_digits;

	// reciprocal multiplies, exact for 16-bit dividends
	always_comb begin
		p1 = {17'd0, item.value} * 33'd104858;
		p2 = {17'd0, item.value} * 33'd83887;
		p3 = {17'd0, item.value} * 33'd67109;
		p4 = {17'd0, item.value} * 33'd107375;
		q1 = p1[20 +: 13];
		q2 = p2[23 +: 10];
		q3 = p3[26 +: 7];
		q4 = p4[30 +: 3];
		r0 = item.value - (({3'd0, q1} << 3) + ({3'd0, q1} << 1));
		r1 = q1 - (({3'd0, q2} << 3) + ({3'd0, q2} << 1));
		r2 = q2 - (({3'd0, q3} << 3) + ({3'd0, q3} << 1));
		r3 = q3 - (({4'd0, q4} << 3) + ({4'd0, q4} << 1));
		val_digits[0] = r3[3:0];
		val_digits[1] = r2[3:0];
		val_digits[2] = r1[3:0];
		val_digits[3] = r0[3:0];
	end

	always_comb begin
		tm = {8'd0, item.minutes} * 15'd205;
		th = {8'd0, item.hours} * 15'd205;
		mt_raw = tm[11 +: 4];
		ht_raw = th[11 +: 4];
		mt = (mt_raw >= 4'd10) ? mt_raw - 4'd10 : mt_raw;
		ht = (ht_raw >= 4'd10) ? ht_raw - 4'd10 : ht_raw;
		mo = item.minutes - (({3'd0, mt_raw} << 3) + ({3'd0, mt_raw} << 1));
		ho = item.hours - (({3'd0, ht_raw} << 3) + ({3'd0, ht_raw} << 1));
		time_digits[0] = mt;
		time_digits[1] = mo[3:0];
		time_digits[2] = ht;
		time_digits[3] = ho[3:0];
	end

	always_comb begin
		cmd = '0;
		cmd.digits = val_digits;
		case (item.mode)
			MODE_TICK:    cmd.tick = go;
			MODE_CURRENT: cmd.load_lo = go;
			MODE_VOLTAGE: cmd.load_hi = go;
			MODE_TIME: begin
				cmd.load_hi = go;
				cmd.digits = time_digits;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[hdl/scd_scan.sv]
// Digit store and scan counter; forms the segment pattern and digit select.
// Depends on scd_pkg.
`default_nettype none

module scd_scan import scd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire scd_cmd_t   cmd,
	input  wire logic [7:0] point_mask,
	output out_item_t       result
);

	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic [POS_W-1:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			pos_q <= '0;
		end else begin
			if (cmd.load_lo) begin
				for (int k = 0; k < 4; k++) digits_q[k] <= cmd.digits[k];
			end
			if (cmd.load_hi) begin
				for (int k = 0; k < 4; k++) digits_q[k + 4] <= cmd.digits[k];
			end
			if (cmd.tick) pos_q <= pos_q + 3'd1;
		end
	end

	always_comb begin
		result.segments = {point_mask[pos_q], seg_pattern(digits_q[pos_q])};
		result.digit_select = '0;
		result.digit_select[pos_q] = 1'b1;
	end

endmodule

`default_nettype wire

[dv/tb_scanned_seven_segment_display.sv]
// Testbench for scanned_seven_segment_display: directed and random load/tick items
// checked against an in-bench display predictor, with random idling and backpressure.
// Depends on scd_pkg and the scanned_seven_segment_display RTL.
`timescale 1ns / 100ps

module tb_scanned_seven_segment_display;
	import scd_pkg::*;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pat_e;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int REG_SPARE    = 1;
	localparam logic [PADDR_W-1:0] ADDR_POINT_MASK = PADDR_W'(4 * REG_POINT_MASK);
	localparam logic [PADDR_W-1:0] ADDR_SPARE      = PADDR_W'(4 * REG_SPARE);
	// a..g patterns for digits 9 down to 0
	localparam logic [9:0][6:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
		7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_item_t           in_item  = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_item;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [31:0]        pwdata  = '0;
	logic [31:0]        prdata;
	logic               pready;

	// display predictor state
	logic [3:0]  lit_digits [NUM_DIGITS];
	logic [2:0]  scan_pos = '0;
	logic [7:0]  dp_mask  = '0;
	out_item_t   expected_glyphs [$];

	int          errors = 0;
	int          burst_left = 0;
	bit          no_gaps = 1'b0;
	int          hold_requests = 0;
	int          hold_served = 0;
	int          hold_left = 0;
	int          pat_left = 0;
	int          cycle_cnt = 0;
	stall_pat_e  stall_pat = STALL_NONE;

	scanned_seven_segment_display dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int k = 0; k < NUM_DIGITS; k++) lit_digits[k] = '0;
	end

	function automatic void predict_display(input in_item_t it);
		logic [15:0] v;
		int          base;
		out_item_t   res;
		case (it.mode)
			MODE_CURRENT, MODE_VOLTAGE: begin
				v = it.value;
				base = (it.mode == MODE_VOLTAGE) ? 4 : 0;
				for (int k = 0; k < 4; k++) begin
					lit_digits[base + 3 - k] = 4'(v % 10);
					v = v / 10;
				end
			end
			MODE_TIME: begin
				lit_digits[4] = 4'((it.minutes / 10) % 10);
				lit_digits[5] = 4'(it.minutes % 10);
				lit_digits[6] = 4'((it.hours / 10) % 10);
				lit_digits[7] = 4'(it.hours % 10);
			end
			default: begin
				res.segments[6:0] = (lit_digits[scan_pos] > 4'd9) ? 7'h00
					: GLYPHS[lit_digits[scan_pos]];
				res.segments[7] = dp_mask[scan_pos];
				res.digit_select = 8'd1 << scan_pos;
				expected_glyphs.push_back(res);
				scan_pos = scan_pos + 3'd1;
			end
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		case ($urandom_range(0, 9))
			0:       it.mode = MODE_CURRENT;
			1:       it.mode = MODE_VOLTAGE;
			2:       it.mode = MODE_TIME;
			default: it.mode = MODE_TICK;
		endcase
		case ($urandom_range(0, 3))
			0:       it.value = 16'($urandom);
			1:       it.value = 16'($urandom_range(0, 9999));
			2:       it.value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd10000;
			default: it.value = 16'($urandom_range(0, 99));
		endcase
		if ($urandom_range(0, 7) == 0) begin
			it.hours   = 7'($urandom_range(0, 127));
			it.minutes = 7'($urandom_range(0, 127));
		end else begin
			it.hours   = 7'($urandom_range(0, 99));
			it.minutes = 7'($urandom_range(0, 59));
		end
		return it;
	endfunction

	// valid stays high across back-to-back items; gaps only between bursts
	task automatic send_item(input in_item_t it);
		in_item  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_display(it);
		if (!no_gaps) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
					: $urandom_range(0, 12);
			end
		end
	endtask

	task automatic send_mode(input logic [1:0] m, input logic [15:0] v,
			input logic [6:0] h, input logic [6:0] mi);
		in_item_t it;
		it.mode = m; it.value = v; it.hours = h; it.minutes = mi;
		send_item(it);
	endtask

	task automatic send_ticks(input int n);
		for (int k = 0; k < n; k++) send_mode(MODE_TICK, 16'($urandom), 7'($urandom), 7'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_glyphs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_POINT_MASK) dp_mask = data[7:0];
		@(posedge clk);
	endtask

	task automatic test_reset_state();
		send_ticks(8);
	endtask

	// wide values, time above 99, loads between ticks
	task automatic test_directed_loads();
		send_mode(MODE_CURRENT, 16'hFFFF, 7'd0, 7'd0);
		send_mode(MODE_VOLTAGE, 16'd9999, 7'd0, 7'd0);
		send_ticks(8);
		drain();
		write_reg(ADDR_POINT_MASK, 32'h0000_00FF);
		send_mode(MODE_TIME, 16'd0, 7'd127, 7'd127);
		send_ticks(2);
		send_mode(MODE_CURRENT, 16'd0, 7'd99, 7'd0);
		send_ticks(3);
		send_mode(MODE_TIME, 16'hFFFF, 7'd99, 7'd0);
		send_ticks(3);
	endtask

	task automatic test_random_phase(input logic [31:0] mask_word, input int n);
		drain();
		write_reg(ADDR_POINT_MASK, mask_word);
		repeat (n) send_item(rand_item());
	endtask

	task automatic test_spare_register(input int n);
		drain();
		write_reg(ADDR_SPARE, $urandom);
		repeat (n) send_item(rand_item());
	endtask

	task automatic test_backpressure();
		in_item_t it;
		no_gaps = 1'b1;
		hold_requests++;
		for (int k = 0; k < 150; k++) begin
			it = rand_item();
			it.mode = MODE_TICK;
			send_item(it);
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (pat_left == 0) begin
			stall_pat = stall_pat_e'($urandom_range(0, 3));
			pat_left = $urandom_range(30, 300);
		end else begin
			pat_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_pat)
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: out_stall <= ((cycle_cnt % 5) < 2);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_glyphs.size() == 0) begin
				$display("%0t: unexpected item segments %h digit_select %h",
					$time, out_item.segments, out_item.digit_select);
				errors++;
			end else begin
				want = expected_glyphs.pop_front();
				if (out_item.segments !== want.segments) begin
					$display("%0t: segments expected %h actual %h",
						$time, want.segments, out_item.segments);
					errors++;
				end
				if (out_item.digit_select !== want.digit_select) begin
					$display("%0t: digit_select expected %h actual %h",
						$time, want.digit_select, out_item.digit_select);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_loads();
		test_random_phase(32'h0000_00FF, 400);
		test_backpressure();
		test_random_phase(32'h0000_0000, 400);
		test_random_phase($urandom, 400);
		test_spare_register(400);
		test_random_phase(32'hFFFF_FF00 | 32'($urandom_range(0, 255)), 400);
		drain();
		if (errors == 0) begin
			$display("tb_scanned_seven_segment_display: PASS");
		end else begin
			$display("tb_scanned_seven_segment_display: FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_scanned_seven_segment_display: FAIL");
		$finish;
	end

endmodule

[filelist.f]
hdl/scd_pkg.sv
hdl/scd_convert.sv
hdl/scd_scan.sv
hdl/scanned_seven_segment_display.sv
dv/tb_scanned_seven_segment_display.sv
